// ===== hw/rtl/lav_pkg.sv =====
package lav_pkg;

    // Fixed-point formats
    localparam int UNIT_FRAC = 30;
    localparam int COORD_W   = 32;

    // Stream widths
    localparam int S_DATA_W  = 9 * COORD_W;
    localparam int M_DATA_W  = 12 * COORD_W;

    // Normalizer pipeline depth in cycles, input register to output register
    localparam int NORM_LAT  = 70;

    typedef logic signed [COORD_W-1:0] unit_t;

    localparam unit_t UNIT_ONE  = 32'sh4000_0000;
    localparam unit_t UNIT_MONE = -32'sh4000_0000;
    localparam unit_t SAT_MAX   = 32'sh7FFF_FFFF;
    localparam unit_t SAT_MIN   = 32'sh8000_0000;

endpackage

// ===== hw/rtl/lav_norm.sv =====
module lav_norm #(
    parameter int IN_W = 33
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [IN_W-1:0] in_vec [3],
    output logic                   out_valid,
    output lav_pkg::unit_t         out_vec [3]
);
    import lav_pkg::*;

    localparam int PW    = $clog2(IN_W);
    localparam int NW    = UNIT_FRAC;
    localparam int TOP   = NW - 1;
    localparam int RW    = UNIT_FRAC + 1;
    localparam int SQ_W  = 2 * RW;
    localparam int PRW   = 2 * NW;
    localparam int NUM_W = NW + RW;
    localparam int STEPS = RW;

    logic [NORM_LAT-1:0] vld_reg;

    logic [IN_W-1:0] mag1_reg [3];
    logic [2:0]      sgn1_reg;
    logic [IN_W-1:0] mag2_reg [3];
    logic [2:0]      sgn2_reg;
    logic [IN_W-1:0] max2_reg;
    logic [IN_W-1:0] mag3_reg [3];
    logic [2:0]      sgn3_reg;
    logic [PW-1:0]   pos3_reg;
    logic [PW-1:0]   pos3_next;
    logic            zero3_reg;
    logic [NW-1:0]   nm4_reg [3];
    logic [2:0]      sgn4_reg;
    logic            zero4_reg;
    logic [PRW-1:0]  sq5_reg [3];
    logic [NW-1:0]   nm5_reg [3];
    logic [2:0]      sgn5_reg;
    logic            zero5_reg;

    logic [SQ_W-1:0] sq_x_reg    [0:STEPS];
    logic [RW-1:0]   sq_root_reg [0:STEPS];
    logic [RW+1:0]   sq_rem_reg  [0:STEPS];
    logic [NW-1:0]   sq_nm_reg   [0:STEPS][3];
    logic [2:0]      sq_sgn_reg  [0:STEPS];
    logic            sq_zero_reg [0:STEPS];

    logic [RW-1:0]   dv_rem_reg  [0:STEPS][3];
    logic [RW-1:0]   dv_low_reg  [0:STEPS][3];
    logic [RW-1:0]   dv_q_reg    [0:STEPS][3];
    logic [RW-1:0]   dv_len_reg  [0:STEPS];
    logic [2:0]      dv_sgn_reg  [0:STEPS];
    logic            dv_zero_reg [0:STEPS];

    logic [NUM_W-1:0] numer [3];

    unit_t out_reg [3];

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NORM_LAT-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NORM_LAT-1];

    // Find the leading one of the largest magnitude
    always_comb begin
        pos3_next = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (max2_reg[b]) begin
                pos3_next = PW'(b);
            end
        end
    end

    // Front stages: magnitude, maximum, scale, squares, sum
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag1_reg[i] <= in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
                sgn1_reg[i] <= in_vec[i][IN_W-1];
            end
            mag2_reg <= mag1_reg;
            sgn2_reg <= sgn1_reg;
            if (mag1_reg[0] >= mag1_reg[1] && mag1_reg[0] >= mag1_reg[2]) begin
                max2_reg <= mag1_reg[0];
            end else if (mag1_reg[1] >= mag1_reg[2]) begin
                max2_reg <= mag1_reg[1];
            end else begin
                max2_reg <= mag1_reg[2];
            end
            mag3_reg  <= mag2_reg;
            sgn3_reg  <= sgn2_reg;
            pos3_reg  <= pos3_next;
            zero3_reg <= (max2_reg == '0);
            for (int i = 0; i < 3; i++) begin
                if (int'(pos3_reg) >= TOP) begin
                    nm4_reg[i] <= NW'(mag3_reg[i] >> (int'(pos3_reg) - TOP));
                end else begin
                    nm4_reg[i] <= NW'(mag3_reg[i] << (TOP - int'(pos3_reg)));
                end
            end
            sgn4_reg  <= sgn3_reg;
            zero4_reg <= zero3_reg;
            for (int i = 0; i < 3; i++) begin
                sq5_reg[i] <= PRW'(nm4_reg[i]) * PRW'(nm4_reg[i]);
            end
            nm5_reg   <= nm4_reg;
            sgn5_reg  <= sgn4_reg;
            zero5_reg <= zero4_reg;
            sq_x_reg[0]    <= SQ_W'(sq5_reg[0]) + SQ_W'(sq5_reg[1]) + SQ_W'(sq5_reg[2]);
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
            sq_nm_reg[0]   <= nm5_reg;
            sq_sgn_reg[0]  <= sgn5_reg;
            sq_zero_reg[0] <= zero5_reg;
        end
    end

    // Square root: one result bit per stage
    for (genvar j = 0; j < STEPS; j++) begin : g_sqrt
        logic [RW+3:0] rsh;
        logic [RW+3:0] trial;

        assign rsh   = {sq_rem_reg[j], sq_x_reg[j][SQ_W-1-2*j -: 2]};
        assign trial = {2'b00, sq_root_reg[j], 2'b01};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rsh >= trial) begin
                    sq_rem_reg[j+1]  <= (RW+2)'(rsh - trial);
                    sq_root_reg[j+1] <= {sq_root_reg[j][RW-2:0], 1'b1};
                end else begin
                    sq_rem_reg[j+1]  <= (RW+2)'(rsh);
                    sq_root_reg[j+1] <= {sq_root_reg[j][RW-2:0], 1'b0};
                end
                sq_x_reg[j+1]    <= sq_x_reg[j];
                sq_nm_reg[j+1]   <= sq_nm_reg[j];
                sq_sgn_reg[j+1]  <= sq_sgn_reg[j];
                sq_zero_reg[j+1] <= sq_zero_reg[j];
            end
        end
    end

    // Form the rounded dividend: mag * 2^30 + len / 2
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            numer[i] = {1'b0, sq_nm_reg[STEPS][i], {NW{1'b0}}}
                     + NUM_W'(sq_root_reg[STEPS][RW-1:1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= RW'(numer[i][NUM_W-1:RW]);
                dv_low_reg[0][i] <= numer[i][RW-1:0];
                dv_q_reg[0][i]   <= '0;
            end
            dv_len_reg[0]  <= sq_root_reg[STEPS];
            dv_sgn_reg[0]  <= sq_sgn_reg[STEPS];
            dv_zero_reg[0] <= sq_zero_reg[STEPS];
        end
    end

    // Restoring division: one quotient bit per stage on all three lanes
    for (genvar k = 0; k < STEPS; k++) begin : g_div
        logic [RW:0] rsh [3];
        logic [RW:0] dvs;

        assign dvs = {1'b0, dv_len_reg[k]};

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rsh[i] = {dv_rem_reg[k][i], dv_low_reg[k][i][RW-1-k]};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (rsh[i] >= dvs) begin
                        dv_rem_reg[k+1][i] <= RW'(rsh[i] - dvs);
                        dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][RW-2:0], 1'b1};
                    end else begin
                        dv_rem_reg[k+1][i] <= RW'(rsh[i]);
                        dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][RW-2:0], 1'b0};
                    end
                end
                dv_low_reg[k+1]  <= dv_low_reg[k];
                dv_len_reg[k+1]  <= dv_len_reg[k];
                dv_sgn_reg[k+1]  <= dv_sgn_reg[k];
                dv_zero_reg[k+1] <= dv_zero_reg[k];
            end
        end
    end

    // Restore signs; a zero vector gives zero
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dv_zero_reg[STEPS]) begin
                    out_reg[i] <= '0;
                end else if (dv_sgn_reg[STEPS][i]) begin
                    out_reg[i] <= -$signed({1'b0, dv_q_reg[STEPS][i]});
                end else begin
                    out_reg[i] <= $signed({1'b0, dv_q_reg[STEPS][i]});
                end
            end
        end
    end

    assign out_vec = out_reg;

    a_lane0_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_vec[0] <= UNIT_ONE && out_vec[0] >= UNIT_MONE))
        else $error("normalized lane 0 out of range");

    a_lane1_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_vec[1] <= UNIT_ONE && out_vec[1] >= UNIT_MONE))
        else $error("normalized lane 1 out of range");

    a_lane2_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_vec[2] <= UNIT_ONE && out_vec[2] >= UNIT_MONE))
        else $error("normalized lane 2 out of range");

endmodule

// ===== hw/rtl/look_at_view_matrix.sv =====
// Channel | Direction | Payload
// s_      | in        | eye xyz, target xyz, upvec xyz (signed Q16.16)
// m_      | out       | rows s, u, -f with offsets (Q2.30 rotation, Q16.16 offsets)
//
// One transfer in per cycle while m_tready does not hold the output.
// The latency is set by two normalizers in series (each a bit-per-stage square
// root and divider) plus the cross products and dot products around them.
// aresetn is synchronous and clears only the valid bits.
// When the output is held by m_tready low, the whole pipeline freezes.
module look_at_view_matrix (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  logic [lav_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // side_x, side_y, side_z, side_offset, upright_x, upright_y, upright_z,
    // upright_offset, back_x, back_y, back_z, back_offset
    output logic [lav_pkg::M_DATA_W-1:0]   m_tdata
);
    import lav_pkg::*;

    localparam int D_W  = COORD_W + 1;
    localparam int UP_W = COORD_W;
    localparam int PR_W = 2 * UNIT_FRAC + 2;
    localparam int CR_W = PR_W + 1;
    localparam int EP_W = 2 * COORD_W;
    localparam int QW   = EP_W - UNIT_FRAC;
    localparam int QU   = CR_W - UNIT_FRAC;
    localparam int FD   = NORM_LAT + 2;
    localparam int ED   = 2 * NORM_LAT + 2;

    function automatic unit_t round_unit(input logic signed [CR_W-1:0] c);
        logic [CR_W-1:0] mag;
        logic [QU-1:0]   q;
        mag = c[CR_W-1] ? CR_W'(-c) : CR_W'(c);
        q   = QU'((mag + (CR_W'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC);
        if (q > QU'(UNIT_ONE)) begin
            q = QU'(UNIT_ONE);
        end
        return c[CR_W-1] ? -$signed({1'b0, q[UNIT_FRAC:0]})
                         : $signed({1'b0, q[UNIT_FRAC:0]});
    endfunction

    function automatic unit_t off_sat(input logic signed [EP_W-1:0] dot, input logic neg);
        logic [EP_W-1:0] mag;
        logic [QW-1:0]   q;
        logic            negative;
        unit_t           r;
        mag      = dot[EP_W-1] ? EP_W'(-dot) : EP_W'(dot);
        q        = QW'((mag + (EP_W'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC);
        negative = dot[EP_W-1] ^ neg;
        if (q[QW-1:COORD_W-1] != '0) begin
            r = negative ? SAT_MIN : SAT_MAX;
        end else if (negative) begin
            r = -$signed({1'b0, q[COORD_W-2:0]});
        end else begin
            r = $signed({1'b0, q[COORD_W-2:0]});
        end
        return r;
    endfunction

    logic adv;

    logic                   v1_reg;
    unit_t                  eye_reg [3];
    logic signed [D_W-1:0]  d_reg   [3];
    logic signed [UP_W-1:0] up_reg  [3];

    logic  f_vld;
    logic  u0_vld;
    logic  s_vld;
    unit_t f_vec  [3];
    unit_t u0_vec [3];
    unit_t s_vec  [3];

    logic                   c1_vld_reg;
    logic                   c2_vld_reg;
    logic signed [PR_W-1:0] cp_reg [6];
    logic signed [CR_W-1:0] cr_reg [3];

    unit_t f_dly_reg   [0:FD-1][3];
    unit_t eye_dly_reg [0:ED-1][3];

    logic [5:0] p_vld_reg;

    logic signed [PR_W-1:0] p1_uf_reg [6];
    logic signed [EP_W-1:0] p1_se_reg [3];
    logic signed [EP_W-1:0] p1_fe_reg [3];
    unit_t                  p1_s_reg  [3];
    unit_t                  p1_f_reg  [3];
    unit_t                  p1_e_reg  [3];

    logic signed [CR_W-1:0] p2_uc_reg [3];
    logic signed [EP_W-1:0] p2_sd_reg;
    logic signed [EP_W-1:0] p2_fd_reg;
    unit_t                  p2_s_reg  [3];
    unit_t                  p2_f_reg  [3];
    unit_t                  p2_e_reg  [3];

    unit_t p3_u_reg [3];
    unit_t p3_s_reg [3];
    unit_t p3_f_reg [3];
    unit_t p3_e_reg [3];
    unit_t p3_so_reg;
    unit_t p3_bo_reg;

    logic signed [EP_W-1:0] p4_ue_reg [3];
    unit_t                  p4_u_reg  [3];
    unit_t                  p4_s_reg  [3];
    unit_t                  p4_f_reg  [3];
    unit_t                  p4_so_reg;
    unit_t                  p4_bo_reg;

    logic signed [EP_W-1:0] p5_ud_reg;
    unit_t                  p5_u_reg  [3];
    unit_t                  p5_s_reg  [3];
    unit_t                  p5_f_reg  [3];
    unit_t                  p5_so_reg;
    unit_t                  p5_bo_reg;

    logic [M_DATA_W-1:0] m_tdata_reg;

    // Freeze the whole pipeline while a result waits
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Track valid bits outside the normalizers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            p_vld_reg  <= '0;
        end else if (adv) begin
            v1_reg     <= s_tvalid;
            c1_vld_reg <= f_vld;
            c2_vld_reg <= c1_vld_reg;
            p_vld_reg  <= {p_vld_reg[4:0], s_vld};
        end
    end

    // Capture the transfer and form target minus eye
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                eye_reg[i] <= $signed(s_tdata[COORD_W*i +: COORD_W]);
                d_reg[i]   <= D_W'($signed(s_tdata[COORD_W*(3+i) +: COORD_W]))
                            - D_W'($signed(s_tdata[COORD_W*i +: COORD_W]));
                up_reg[i]  <= $signed(s_tdata[COORD_W*(6+i) +: COORD_W]);
            end
        end
    end

    lav_norm #(.IN_W(D_W)) u_norm_fwd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v1_reg),
        .in_vec    (d_reg),
        .out_valid (f_vld),
        .out_vec   (f_vec)
    );

    lav_norm #(.IN_W(UP_W)) u_norm_up (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v1_reg),
        .in_vec    (up_reg),
        .out_valid (u0_vld),
        .out_vec   (u0_vec)
    );

    // Cross product f x u0, products then differences
    always_ff @(posedge aclk) begin
        if (adv) begin
            cp_reg[0] <= PR_W'(PR_W'(f_vec[1]) * PR_W'(u0_vec[2]));
            cp_reg[1] <= PR_W'(PR_W'(f_vec[2]) * PR_W'(u0_vec[1]));
            cp_reg[2] <= PR_W'(PR_W'(f_vec[2]) * PR_W'(u0_vec[0]));
            cp_reg[3] <= PR_W'(PR_W'(f_vec[0]) * PR_W'(u0_vec[2]));
            cp_reg[4] <= PR_W'(PR_W'(f_vec[0]) * PR_W'(u0_vec[1]));
            cp_reg[5] <= PR_W'(PR_W'(f_vec[1]) * PR_W'(u0_vec[0]));
            for (int i = 0; i < 3; i++) begin
                cr_reg[i] <= CR_W'(cp_reg[2*i]) - CR_W'(cp_reg[2*i+1]);
            end
        end
    end

    lav_norm #(.IN_W(CR_W)) u_norm_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (c2_vld_reg),
        .in_vec    (cr_reg),
        .out_valid (s_vld),
        .out_vec   (s_vec)
    );

    // Hold f and eye until the side vector is ready
    always_ff @(posedge aclk) begin
        if (adv) begin
            f_dly_reg[0]   <= f_vec;
            eye_dly_reg[0] <= eye_reg;
            for (int k = 1; k < FD; k++) begin
                f_dly_reg[k] <= f_dly_reg[k-1];
            end
            for (int k = 1; k < ED; k++) begin
                eye_dly_reg[k] <= eye_dly_reg[k-1];
            end
        end
    end

    // Back end: s x f, dot products, rounding and saturation
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_uf_reg[0] <= PR_W'(PR_W'(s_vec[1]) * PR_W'(f_dly_reg[FD-1][2]));
            p1_uf_reg[1] <= PR_W'(PR_W'(s_vec[2]) * PR_W'(f_dly_reg[FD-1][1]));
            p1_uf_reg[2] <= PR_W'(PR_W'(s_vec[2]) * PR_W'(f_dly_reg[FD-1][0]));
            p1_uf_reg[3] <= PR_W'(PR_W'(s_vec[0]) * PR_W'(f_dly_reg[FD-1][2]));
            p1_uf_reg[4] <= PR_W'(PR_W'(s_vec[0]) * PR_W'(f_dly_reg[FD-1][1]));
            p1_uf_reg[5] <= PR_W'(PR_W'(s_vec[1]) * PR_W'(f_dly_reg[FD-1][0]));
            for (int i = 0; i < 3; i++) begin
                p1_se_reg[i] <= EP_W'(s_vec[i]) * EP_W'(eye_dly_reg[ED-1][i]);
                p1_fe_reg[i] <= EP_W'(f_dly_reg[FD-1][i]) * EP_W'(eye_dly_reg[ED-1][i]);
            end
            p1_s_reg <= s_vec;
            p1_f_reg <= f_dly_reg[FD-1];
            p1_e_reg <= eye_dly_reg[ED-1];

            for (int i = 0; i < 3; i++) begin
                p2_uc_reg[i] <= CR_W'(p1_uf_reg[2*i]) - CR_W'(p1_uf_reg[2*i+1]);
            end
            p2_sd_reg <= p1_se_reg[0] + p1_se_reg[1] + p1_se_reg[2];
            p2_fd_reg <= p1_fe_reg[0] + p1_fe_reg[1] + p1_fe_reg[2];
            p2_s_reg  <= p1_s_reg;
            p2_f_reg  <= p1_f_reg;
            p2_e_reg  <= p1_e_reg;

            for (int i = 0; i < 3; i++) begin
                p3_u_reg[i] <= round_unit(p2_uc_reg[i]);
            end
            p3_so_reg <= off_sat(p2_sd_reg, 1'b1);
            p3_bo_reg <= off_sat(p2_fd_reg, 1'b0);
            p3_s_reg  <= p2_s_reg;
            p3_f_reg  <= p2_f_reg;
            p3_e_reg  <= p2_e_reg;

            for (int i = 0; i < 3; i++) begin
                p4_ue_reg[i] <= EP_W'(p3_u_reg[i]) * EP_W'(p3_e_reg[i]);
            end
            p4_u_reg  <= p3_u_reg;
            p4_s_reg  <= p3_s_reg;
            p4_f_reg  <= p3_f_reg;
            p4_so_reg <= p3_so_reg;
            p4_bo_reg <= p3_bo_reg;

            p5_ud_reg <= p4_ue_reg[0] + p4_ue_reg[1] + p4_ue_reg[2];
            p5_u_reg  <= p4_u_reg;
            p5_s_reg  <= p4_s_reg;
            p5_f_reg  <= p4_f_reg;
            p5_so_reg <= p4_so_reg;
            p5_bo_reg <= p4_bo_reg;

            m_tdata_reg <= {p5_bo_reg, -p5_f_reg[2], -p5_f_reg[1], -p5_f_reg[0],
                            off_sat(p5_ud_reg, 1'b1), p5_u_reg[2], p5_u_reg[1], p5_u_reg[0],
                            p5_so_reg, p5_s_reg[2], p5_s_reg[1], p5_s_reg[0]};
        end
    end

    assign m_tvalid = p_vld_reg[5];
    assign m_tdata  = m_tdata_reg;

    a_norm_align: assert property (@(posedge aclk) disable iff (!aresetn)
        f_vld == u0_vld)
        else $error("forward and up normalizers out of step");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_ready_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_zero_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[287:256] == '0 && m_tdata[319:288] == '0
         && m_tdata[351:320] == '0)
        |-> (m_tdata[31:0] == '0 && m_tdata[63:32] == '0 && m_tdata[95:64] == '0))
        else $error("zero forward vector with nonzero side vector");

endmodule

// ===== verif/tb_look_at_view_matrix.sv =====
module tb_look_at_view_matrix;
    import lav_pkg::*;

    localparam int PIPE_LAT   = 148;
    localparam int LONG_HOLD  = 400;

    typedef logic signed [31:0] coord_t;

    typedef struct packed {
        coord_t upvec_z, upvec_y, upvec_x;
        coord_t target_z, target_y, target_x;
        coord_t eye_z, eye_y, eye_x;
    } camera_t;

    typedef struct packed {
        coord_t back_offset, back_z, back_y, back_x;
        coord_t upright_offset, upright_z, upright_y, upright_x;
        coord_t side_offset, side_z, side_y, side_x;
    } view_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // side_x, side_y, side_z, side_offset, upright_x, upright_y, upright_z,
    // upright_offset, back_x, back_y, back_z, back_offset
    logic [M_DATA_W-1:0]   m_tdata;

    view_t  pending_views[$];
    int     error_count = 0;
    int     views_sent = 0;
    int     views_checked = 0;
    bit     send_gaps = 1'b1;
    bit     drain_gaps = 1'b1;
    int     hold_cycles = 0;
    int     hold_requests = 0;
    int     hold_grants = 0;

    look_at_view_matrix DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Unsigned magnitude of a 64-bit signed value
    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale to unit length in Q2.30; zero vector stays zero
    task automatic unit_vec(input logic signed [63:0] v[3], output logic signed [63:0] r[3]);
        logic [63:0] mag[3];
        logic [63:0] m, sum, len;
        logic [127:0] q;
        int left, right;
        m = 0; sum = 0; left = 0; right = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = abs64(v[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            for (int i = 0; i < 3; i++) r[i] = 0;
            return;
        end
        while (m >= (64'd1 << 30)) begin m = m >> 1; right++; end
        while (m < (64'd1 << 29)) begin m = m << 1; left++; end
        for (int i = 0; i < 3; i++) begin
            mag[i] = (mag[i] >> right) << left;
            sum = sum + mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ({64'd0, mag[i]} << UNIT_FRAC) + (len >> 1);
            q = q / len;
            r[i] = v[i] < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
        end
    endtask

    function automatic logic signed [127:0] round_away(input logic signed [127:0] x, input int sh);
        logic [127:0] q;
        q = ((x < 0 ? -x : x) + (128'd1 << (sh - 1))) >> sh;
        return x < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic coord_t offset_sat(input logic signed [127:0] d);
        logic signed [127:0] v;
        v = round_away(d, UNIT_FRAC);
        if (v > 128'sh7FFF_FFFF) v = 128'sh7FFF_FFFF;
        if (v < -128'sh8000_0000) v = -128'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] dot_with_eye(input logic signed [63:0] a[3],
                                                         input logic signed [63:0] e[3]);
        logic signed [127:0] acc;
        acc = 0;
        for (int i = 0; i < 3; i++) acc = acc + 128'(a[i]) * 128'(e[i]);
        return acc;
    endfunction

    task automatic cross3(input logic signed [63:0] a[3], input logic signed [63:0] b[3],
                          output logic signed [63:0] r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endtask

    // Compute the expected view rows for one camera
    task automatic predict_view(input camera_t c, output view_t v);
        logic signed [63:0] eye[3], dir[3], up[3], fwd[3], up0[3], cr[3], side[3], upr[3];
        logic signed [63:0] t;
        eye = '{64'(c.eye_x), 64'(c.eye_y), 64'(c.eye_z)};
        dir = '{64'(c.target_x) - eye[0], 64'(c.target_y) - eye[1], 64'(c.target_z) - eye[2]};
        up  = '{64'(c.upvec_x), 64'(c.upvec_y), 64'(c.upvec_z)};
        unit_vec(dir, fwd);
        unit_vec(up, up0);
        cross3(fwd, up0, cr);
        unit_vec(cr, side);
        cross3(side, fwd, cr);
        for (int i = 0; i < 3; i++) begin
            t = 64'(round_away(128'(cr[i]), UNIT_FRAC));
            if (t > 64'sd1073741824) t = 64'sd1073741824;
            if (t < -64'sd1073741824) t = -64'sd1073741824;
            upr[i] = t;
        end
        v.side_x = side[0][31:0]; v.side_y = side[1][31:0]; v.side_z = side[2][31:0];
        v.upright_x = upr[0][31:0]; v.upright_y = upr[1][31:0]; v.upright_z = upr[2][31:0];
        v.back_x = 32'(-fwd[0]); v.back_y = 32'(-fwd[1]); v.back_z = 32'(-fwd[2]);
        v.side_offset    = offset_sat(-dot_with_eye(side, eye));
        v.upright_offset = offset_sat(-dot_with_eye(upr, eye));
        v.back_offset    = offset_sat(dot_with_eye(fwd, eye));
    endtask

    // Offer one camera and hold until the transfer; valid stays up for the next one
    task automatic send_camera(input camera_t c);
        view_t v;
        int gap;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        predict_view(c, v);
        pending_views.push_back(v);
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        views_sent++;
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic camera_t rand_camera();
        camera_t c;
        c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
        c.eye_x = rand_coord(); c.eye_y = rand_coord(); c.eye_z = rand_coord();
        c.target_x = rand_coord(); c.target_y = rand_coord(); c.target_z = rand_coord();
        c.upvec_x = rand_coord(); c.upvec_y = rand_coord(); c.upvec_z = rand_coord();
        case ($urandom_range(0, 9))
            0: begin c.target_x = c.eye_x; c.target_y = c.eye_y; c.target_z = c.eye_z; end
            1: begin c.upvec_x = 0; c.upvec_y = 0; c.upvec_z = 0; end
            2: begin
                c.upvec_x = c.target_x - c.eye_x;
                c.upvec_y = c.target_y - c.eye_y;
                c.upvec_z = c.target_z - c.eye_z;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic camera_t make_camera(input coord_t ex, ey, ez, tx, ty, tz, ux, uy, uz);
        camera_t c;
        c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
        c.target_x = tx; c.target_y = ty; c.target_z = tz;
        c.upvec_x = ux; c.upvec_y = uy; c.upvec_z = uz;
        return c;
    endfunction

    task automatic test_directed();
        coord_t one, mx, mn;
        one = 32'sh0001_0000; mx = 32'sh7FFF_FFFF; mn = 32'sh8000_0000;
        send_camera(make_camera(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
        send_camera(make_camera(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0));
        send_camera(make_camera(0, 0, 0, one, 0, 0, 0, 0, 0));
        send_camera(make_camera(0, 0, 0, 0, one, 0, 0, 3 * one, 0));
        send_camera(make_camera(0, 0, 0, 0, -one, 0, 0, one, 0));
        send_camera(make_camera(mx, mx, mx, mn, mn, mn, 0, one, 0));
        send_camera(make_camera(mn, mn, mn, mx, mx, mx, mx, mn, mx));
        send_camera(make_camera(mx, mn, mx, 0, 0, 0, mn, mn, mn));
        send_camera(make_camera(mn, 0, mx, mx, 0, mn, 1, 1, 1));
        send_camera(make_camera(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_camera(make_camera(mx, mx, mx, mx - 1, mx, mx, 0, 0, 1));
        send_camera(make_camera(-1, -1, -1, 0, 0, 0, mx, 0, 0));
        send_camera(make_camera(0, 0, 0, one, one, one, -one, one, -one));
        send_camera(make_camera(mn, mn, mn, mn, mn, mn, mn, mn, mn));
        send_camera(make_camera(-mx, -mx, -mx, mx, mx, 0, 0, 0, mn));
        send_camera(make_camera(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0,
                                32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF));
    endtask

    // Keep offering while the result side holds off, so the pipeline fills
    task automatic test_backpressure();
        hold_requests++;
        repeat (300) send_camera(rand_camera());
    endtask

    task automatic test_random(input int n);
        repeat (n) send_camera(rand_camera());
    endtask

    // Result-side ready: random stall bursts, a long hold on request
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (hold_grants < hold_requests) begin
            hold_grants <= hold_grants + 1;
            hold_cycles <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (!drain_gaps || !m_tready) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            hold_cycles <= $urandom_range(0, 18);
        end
    end

    // Compare each result transfer with the oldest expected view
    always @(posedge aclk) begin
        view_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_views.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = pending_views.pop_front();
                views_checked++;
                if (got !== want) begin
                    for (int i = 0; i < 12; i++)
                        if (got[i*32 +: 32] !== want[i*32 +: 32]) begin
                            $display("%0t: field %0d expected %h actual %h",
                                     $time, i, want[i*32 +: 32], got[i*32 +: 32]);
                        end
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(1000);
        send_gaps = 1'b0;
        drain_gaps = 1'b0;
        test_random(300);
        s_tvalid <= 1'b0;
        while (pending_views.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 10) @(posedge aclk);
        $display("Sent %0d cameras incl. degenerate, extreme and stalled cases; %0d checked.",
                 views_sent, views_checked);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
